### rtl/ubd_pkg.sv
`timescale 1ns / 1ps

package ubd_pkg;

	localparam int CLOCK_W = 30;
	localparam int BAUD_W = 24;
	localparam int WORD_W = 16;

	// clock_hz * 25 needs 35 bits; the divisor is baud scaled by 2 or 4.
	localparam int NUM_W = 35;
	localparam int DEN_W = BAUD_W + 2;

	// Quotients of 2**19 and more always saturate, so only 19 quotient bits
	// are developed; the numerator bits above them seed the remainder.
	localparam int QUO_W = 19;
	localparam int HI_W = NUM_W - QUO_W;
	localparam int DIV_STEPS = QUO_W;

	localparam logic [NUM_W-1:0] CLOCK_MUL = NUM_W'(25);

	// Reciprocal of 100 for a 19-bit shift, exact after one correction.
	localparam int RECIP_W = 13;
	localparam int RECIP_SHIFT = 19;
	localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);

	localparam int MANT_W = 13;
	localparam int REM_W = 7;
	localparam int FNUM_W = 11;
	localparam int FRAC_W = 5;

	localparam logic [MANT_W-1:0] MANT_MAX = MANT_W'(4095);
	localparam logic [REM_W-1:0] HUNDRED = REM_W'(100);
	localparam logic [FNUM_W-1:0] ROUND_HALF = FNUM_W'(50);
	localparam logic [FRAC_W-1:0] UNITS_16 = FRAC_W'(16);
	localparam logic [FRAC_W-1:0] UNITS_8 = FRAC_W'(8);
	localparam logic [WORD_W-1:0] WORD_SAT = {WORD_W{1'b1}};

	localparam int CFG_DATA_W = CLOCK_W;

	typedef enum logic {
		CFG_CLOCK_HZ = 1'b0,
		CFG_OVERSAMPLE = 1'b1
	} cfg_index_t;

	// Payload of one item as it moves through the divider.
	typedef struct packed {
		logic sat;
		logic over8;
		logic [DEN_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QUO_W-1:0] nq;
	} div_t;

endpackage

### rtl/ubd_front.sv
`timescale 1ns / 1ps

module ubd_front (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  logic [ubd_pkg::BAUD_W-1:0] line_rate,
	input  logic [ubd_pkg::CLOCK_W-1:0] clock_hz,
	input  logic over8,
	output logic vld_s2,
	output ubd_pkg::div_t d_s2
);
	import ubd_pkg::*;

	logic vld_s1;
	logic [NUM_W-1:0] num_s1;
	logic [DEN_W-1:0] den_s1;
	logic over8_s1;
	logic [HI_W-1:0] num_hi;
	div_t d_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= NUM_W'(clock_hz) * CLOCK_MUL;
			den_s1 <= over8 ? {1'b0, line_rate, 1'b0} : {line_rate, 2'b00};
			over8_s1 <= over8;
			d_s2 <= d_nxt;
		end
	end

	// If the top numerator bits already reach the divisor, the quotient is
	// at least 2**19 and the word saturates. A zero baud rate lands here too.
	always_comb begin
		num_hi = num_s1[NUM_W-1:QUO_W];
		d_nxt.sat = (DEN_W'(num_hi) >= den_s1);
		d_nxt.over8 = over8_s1;
		d_nxt.rem = DEN_W'(num_hi);
		d_nxt.den = den_s1;
		d_nxt.nq = num_s1[QUO_W-1:0];
	end

endmodule

### rtl/ubd_div_step.sv
`timescale 1ns / 1ps

module ubd_div_step (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  ubd_pkg::div_t d_in,
	output logic vld_s1,
	output ubd_pkg::div_t d_s1
);
	import ubd_pkg::*;

	logic [DEN_W:0] r2;
	logic [DEN_W:0] diff;
	logic ge;
	div_t d_nxt;

	// One restoring step: numerator bits shift out of the top of nq while
	// quotient bits shift in at the bottom.
	always_comb begin
		r2 = {d_in.rem, d_in.nq[QUO_W-1]};
		diff = r2 - {1'b0, d_in.den};
		ge = (r2 >= {1'b0, d_in.den});
		d_nxt = d_in;
		d_nxt.rem = ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
		d_nxt.nq = {d_in.nq[QUO_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= d_nxt;
		end
	end

endmodule

### rtl/ubd_post.sv
`timescale 1ns / 1ps

module ubd_post (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  ubd_pkg::div_t d_in,
	output logic vld_s4,
	output logic [ubd_pkg::WORD_W-1:0] word_s4,
	output logic oor_s4
);
	import ubd_pkg::*;

	logic [3:1] vld_q;
	logic [QUO_W-1:0] quo_s1;
	logic [MANT_W-1:0] qest_s1;
	logic [2:0] sat_q;
	logic [2:0] over8_q;
	logic [MANT_W-1:0] mant_s2;
	logic [REM_W-1:0] rem_s2;
	logic [MANT_W-1:0] mant_s3;
	logic [FRAC_W-1:0] frac_s3;

	logic [QUO_W+RECIP_W-1:0] qprod;
	logic [QUO_W+1:0] prod100;
	logic [QUO_W+1:0] qdiff;
	logic [MANT_W-1:0] mant_nxt;
	logic [REM_W-1:0] rem_nxt;
	logic [FNUM_W-1:0] fnum;
	logic [FNUM_W+RECIP_W-1:0] fprod;
	logic carry;
	logic [MANT_W-1:0] mant_fin;
	logic [3:0] frac_fin;
	logic sat_fin;

	always_comb begin
		qprod = (QUO_W+RECIP_W)'(d_in.nq) * (QUO_W+RECIP_W)'(RECIP_100);

		// The estimate is at most one too large; a negative remainder fixes it.
		prod100 = (QUO_W+2)'(qest_s1) * (QUO_W+2)'(HUNDRED);
		qdiff = (QUO_W+2)'(quo_s1) - prod100;
		if (qdiff[QUO_W+1]) begin
			mant_nxt = qest_s1 - MANT_W'(1);
			rem_nxt = qdiff[REM_W-1:0] + HUNDRED;
		end else begin
			mant_nxt = qest_s1;
			rem_nxt = qdiff[REM_W-1:0];
		end

		// Round the remainder half up to eighths or sixteenths.
		fnum = over8_q[1] ? {1'b0, rem_s2, 3'b000} : {rem_s2, 4'b0000};
		fnum = fnum + ROUND_HALF;
		fprod = (FNUM_W+RECIP_W)'(fnum) * (FNUM_W+RECIP_W)'(RECIP_100);

		carry = over8_q[2] ? (frac_s3 >= UNITS_8) : (frac_s3 >= UNITS_16);
		mant_fin = mant_s3 + MANT_W'(carry);
		if (carry) begin
			frac_fin = 4'b0000;
		end else if (over8_q[2]) begin
			frac_fin = {1'b0, frac_s3[2:0]};
		end else begin
			frac_fin = frac_s3[3:0];
		end
		sat_fin = sat_q[2] || (mant_fin > MANT_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[2:1], vld_in};
			vld_s4 <= vld_q[3];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s1 <= d_in.nq;
			qest_s1 <= qprod[QUO_W+RECIP_W-1:RECIP_SHIFT];
			sat_q <= {sat_q[1:0], d_in.sat};
			over8_q <= {over8_q[1:0], d_in.over8};
			mant_s2 <= mant_nxt;
			rem_s2 <= rem_nxt;
			mant_s3 <= mant_s2;
			frac_s3 <= fprod[RECIP_SHIFT+FRAC_W-1:RECIP_SHIFT];
			word_s4 <= sat_fin ? WORD_SAT : {mant_fin[WORD_W-5:0], frac_fin};
			oor_s4 <= sat_fin;
		end
	end

endmodule

### rtl/uart_baud_divisor_calc.sv
`timescale 1ns / 1ps

// Baud divisor calculator: each item is a requested baud rate, and each
// result is the UART baud register word (mantissa in bits 15:4, fraction in
// bits 3:0) for the configured clock and oversampling mode, or 65535 with
// out_of_range set when the mantissa needs more than 12 bits. An item can
// enter every cycle unless the result side stalls; the pipe holds the
// 19 restoring divide steps, one per stage, plus two front stages
// that form the scaled clock and four that split the quotient into mantissa
// and rounded fraction. A stall on the result side freezes the whole pipe.
// Configuration is sampled as items enter.
module uart_baud_divisor_calc (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [ubd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic baud_valid,
	output logic baud_stall,
	input  logic [ubd_pkg::BAUD_W-1:0] line_rate,
	output logic result_valid,
	input  logic result_stall,
	output logic [ubd_pkg::WORD_W-1:0] divisor_word,
	output logic out_of_range
);
	import ubd_pkg::*;

	logic [CLOCK_W-1:0] clock_hz_q;
	logic over8_q;
	logic adv;
	logic [DIV_STEPS:0] div_vld;
	div_t div_pl [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLOCK_W'(16000000);
			over8_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_CLOCK_HZ: clock_hz_q <= cfg_data[CLOCK_W-1:0];
				CFG_OVERSAMPLE: over8_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign adv = !(result_valid && result_stall);
	assign baud_stall = !adv;

	ubd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.vld_in(baud_valid),
		.line_rate(line_rate),
		.clock_hz(clock_hz_q),
		.over8(over8_q),
		.vld_s2(div_vld[0]),
		.d_s2(div_pl[0])
	);

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		ubd_div_step u_step (
			.clk(clk),
			.arst_n(arst_n),
			.en(adv),
			.vld_in(div_vld[i]),
			.d_in(div_pl[i]),
			.vld_s1(div_vld[i+1]),
			.d_s1(div_pl[i+1])
		);
	end

	ubd_post u_post (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.vld_in(div_vld[DIV_STEPS]),
		.d_in(div_pl[DIV_STEPS]),
		.vld_s4(result_valid),
		.word_s4(divisor_word),
		.oor_s4(out_of_range)
	);

	a_sat_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && out_of_range |-> divisor_word == WORD_SAT)
		else $error("saturated result without an all-ones word");

	a_frac8: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !out_of_range && over8_q |-> !divisor_word[3])
		else $error("eighths fraction uses bit 3");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("stalled result item dropped");

endmodule
